// File: design/whc_pkg.sv
// Shared types and constants for the WAV header checker.
`default_nettype none

package whc_pkg;

  // Header geometry
  localparam int unsigned HDR_LEN  = 44;
  localparam int unsigned POS_W    = 6;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(HDR_LEN);

  // First byte position of each field
  localparam logic [POS_W-1:0] POS_RIFF_SIZE   = 6'd4;
  localparam logic [POS_W-1:0] POS_WAVE_TAG    = 6'd8;
  localparam logic [POS_W-1:0] POS_FMT_TAG     = 6'd12;
  localparam logic [POS_W-1:0] POS_FMT_SIZE    = 6'd16;
  localparam logic [POS_W-1:0] POS_FORMAT      = 6'd20;
  localparam logic [POS_W-1:0] POS_CHANNELS    = 6'd22;
  localparam logic [POS_W-1:0] POS_RATE        = 6'd24;
  localparam logic [POS_W-1:0] POS_BYTE_RATE   = 6'd28;
  localparam logic [POS_W-1:0] POS_BLOCK_ALIGN = 6'd32;
  localparam logic [POS_W-1:0] POS_BITS        = 6'd34;
  localparam logic [POS_W-1:0] POS_DATA_TAG    = 6'd36;
  localparam logic [POS_W-1:0] POS_DATA_SIZE   = 6'd40;

  // Expected tag words (little-endian ASCII) and fixed values
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_SIZE_PCM   = 32'd16;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;
  localparam logic [15:0] CHANNELS_MONO  = 16'd1;
  localparam logic [33:0] RIFF_SIZE_BASE = 34'd20;

  // Error mask bit positions, in header order
  localparam int unsigned ERR_W           = 13;
  localparam int unsigned ERR_RIFF        = 0;
  localparam int unsigned ERR_RIFF_SIZE   = 1;
  localparam int unsigned ERR_WAVE        = 2;
  localparam int unsigned ERR_FMT         = 3;
  localparam int unsigned ERR_FMT_SIZE    = 4;
  localparam int unsigned ERR_PCM         = 5;
  localparam int unsigned ERR_MONO        = 6;
  localparam int unsigned ERR_RATE        = 7;
  localparam int unsigned ERR_BYTE_RATE   = 8;
  localparam int unsigned ERR_BLOCK_ALIGN = 9;
  localparam int unsigned ERR_BITS        = 10;
  localparam int unsigned ERR_DATA        = 11;
  localparam int unsigned ERR_DATA_SIZE   = 12;

  // Divider
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = 6;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_START,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;    // shift the incoming byte into its field
    logic [POS_W-1:0] byte_pos;   // header position of that byte
    logic             div_start;  // launch the duration division
    logic             mask_load;  // register the check results
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: design/whc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module whc_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [whc_pkg::DIV_W-1:0] dividend,
  input  wire logic [whc_pkg::DIV_W-1:0] divisor,
  output logic                          busy,
  output logic [whc_pkg::DIV_W-1:0]     quotient
);
  import whc_pkg::*;

  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  // One restoring step
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = ~diff[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DIV_CNT_W'(DIV_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (count != '0) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign busy     = (count != '0);
  assign quotient = quo;

endmodule

`default_nettype wire

// File: design/whc_datapath.sv
// Field assembly, header checks and duration division.
`default_nettype none

module whc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire whc_pkg::cmd_t                 cmd,
  output whc_pkg::sts_t                      sts,
  input  wire logic [7:0]                    data_byte,
  output logic [whc_pkg::ERR_W-1:0]          error_mask,
  output logic [31:0]                        sample_rate,
  output logic [31:0]                        byte_rate,
  output logic [15:0]                        bits_per_sample,
  output logic [31:0]                        data_size,
  output logic [31:0]                        duration_seconds
);
  import whc_pkg::*;

  logic [31:0] riff_tag, riff_size, wave_tag, fmt_tag, fmt_size;
  logic [15:0] format_code, channel_count;
  logic [31:0] rate_reg, byte_rate_reg;
  logic [15:0] block_align_reg, sample_bits_reg;
  logic [31:0] data_tag, data_size_reg;

  logic [31:0]      chan_bits;
  logic [63:0]      br_prod;
  logic [33:0]      size_sum;
  logic [ERR_W-1:0] mask_next;
  logic [ERR_W-1:0] mask_reg;
  logic [31:0]      quotient;
  logic             div_busy;

  // Little-endian assembly: each byte shifts in from the top of its field
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      priority if (cmd.byte_pos < POS_RIFF_SIZE) begin
        riff_tag <= {data_byte, riff_tag[31:8]};
      end else if (cmd.byte_pos < POS_WAVE_TAG) begin
        riff_size <= {data_byte, riff_size[31:8]};
      end else if (cmd.byte_pos < POS_FMT_TAG) begin
        wave_tag <= {data_byte, wave_tag[31:8]};
      end else if (cmd.byte_pos < POS_FMT_SIZE) begin
        fmt_tag <= {data_byte, fmt_tag[31:8]};
      end else if (cmd.byte_pos < POS_FORMAT) begin
        fmt_size <= {data_byte, fmt_size[31:8]};
      end else if (cmd.byte_pos < POS_CHANNELS) begin
        format_code <= {data_byte, format_code[15:8]};
      end else if (cmd.byte_pos < POS_RATE) begin
        channel_count <= {data_byte, channel_count[15:8]};
      end else if (cmd.byte_pos < POS_BYTE_RATE) begin
        rate_reg <= {data_byte, rate_reg[31:8]};
      end else if (cmd.byte_pos < POS_BLOCK_ALIGN) begin
        byte_rate_reg <= {data_byte, byte_rate_reg[31:8]};
      end else if (cmd.byte_pos < POS_BITS) begin
        block_align_reg <= {data_byte, block_align_reg[15:8]};
      end else if (cmd.byte_pos < POS_DATA_TAG) begin
        sample_bits_reg <= {data_byte, sample_bits_reg[15:8]};
      end else if (cmd.byte_pos < POS_DATA_SIZE) begin
        data_tag <= {data_byte, data_tag[31:8]};
      end else begin
        data_size_reg <= {data_byte, data_size_reg[31:8]};
      end
    end
  end

  // Expected rates: two registered multiplies, settled long before the last byte
  always_ff @(posedge clk) begin
    chan_bits <= 32'(channel_count) * 32'(sample_bits_reg);
    br_prod   <= 64'(rate_reg) * 64'(chan_bits);
  end

  // Header checks
  always_comb begin
    size_sum  = RIFF_SIZE_BASE + 34'(fmt_size) + 34'(data_size_reg);
    mask_next = '0;
    mask_next[ERR_RIFF]        = (riff_tag != TAG_RIFF);
    mask_next[ERR_RIFF_SIZE]   = (34'(riff_size) != size_sum);
    mask_next[ERR_WAVE]        = (wave_tag != TAG_WAVE);
    mask_next[ERR_FMT]         = (fmt_tag != TAG_FMT);
    mask_next[ERR_FMT_SIZE]    = (fmt_size != FMT_SIZE_PCM);
    mask_next[ERR_PCM]         = (format_code != FORMAT_PCM);
    mask_next[ERR_MONO]        = (channel_count != CHANNELS_MONO);
    mask_next[ERR_RATE]        = (rate_reg == '0);
    mask_next[ERR_BYTE_RATE]   = (64'(byte_rate_reg) != (br_prod >> 3));
    mask_next[ERR_BLOCK_ALIGN] = (32'(block_align_reg) != (chan_bits >> 3));
    mask_next[ERR_BITS]        = (sample_bits_reg == '0);
    mask_next[ERR_DATA]        = (data_tag != TAG_DATA);
    mask_next[ERR_DATA_SIZE]   = (data_size_reg == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.mask_load) begin
      mask_reg <= mask_next;
    end
  end

  // Duration = data size / byte rate
  whc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (data_size_reg),
    .divisor  (byte_rate_reg),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sts.div_busy     = div_busy;
  assign error_mask       = mask_reg;
  assign sample_rate      = rate_reg;
  assign byte_rate        = byte_rate_reg;
  assign bits_per_sample  = sample_bits_reg;
  assign data_size        = data_size_reg;
  assign duration_seconds = (byte_rate_reg == '0) ? '0 : quotient;

endmodule

`default_nettype wire

// File: design/whc_ctrl.sv
// Controller: byte position, handshakes and sequencing of check and division.
`default_nettype none

module whc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          hdr_valid,
  output logic               hdr_stall,
  input  wire logic          start_req,
  output logic               res_valid,
  input  wire logic          res_stall,
  output whc_pkg::cmd_t      cmd,
  input  wire whc_pkg::sts_t sts
);
  import whc_pkg::*;

  state_t           state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] eff_pos;
  logic             accept;
  logic             in_header;

  // Transfer decode and effective position
  always_comb begin
    accept    = hdr_valid && (state == ST_COLLECT);
    eff_pos   = start_req ? '0 : pos;
    in_header = (eff_pos < POS_END);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (accept && (eff_pos == POS_LAST)) state_next = ST_START;
      end
      ST_START: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (!sts.div_busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!res_stall) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Position counter holds at the header end until the next start
  always_comb begin
    pos_next = pos;
    if (accept && in_header) pos_next = eff_pos + 1'b1;
  end

  // Outputs
  always_comb begin
    hdr_stall     = (state != ST_COLLECT);
    res_valid     = (state == ST_RESULT);
    cmd.capture   = accept && in_header;
    cmd.byte_pos  = eff_pos;
    cmd.div_start = (state == ST_START);
    cmd.mask_load = (state == ST_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

endmodule

`default_nettype wire

// File: design/wav_header_checker.sv
// Top level of the WAV header checker.
//
// Takes a canonical 44-byte WAV header one byte per transfer on the hdr channel; a byte
// with start_req high is taken as byte 0. Header bytes are accepted one per cycle while hdr_stall is low. After
// the 44th byte the block registers the checks and launches the divider (ST_START), runs the
// one-bit-per-cycle duration divider (ST_DIVIDE), then moves to ST_RESULT and raises res_valid;
// hdr_stall is high from the 44th byte until the result transfer. Bytes after the header are
// accepted and ignored until the next start_req.
`default_nettype none

module wav_header_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        hdr_valid,
  output logic             hdr_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_req,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             header_ok,
  output logic [12:0]      error_mask,
  output logic [31:0]      sample_rate,
  output logic [31:0]      byte_rate,
  output logic [15:0]      bits_per_sample,
  output logic [31:0]      data_size,
  output logic [31:0]      duration_seconds
);
  import whc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  whc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .start_req (start_req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  whc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .data_byte        (data_byte),
    .error_mask       (error_mask),
    .sample_rate      (sample_rate),
    .byte_rate        (byte_rate),
    .bits_per_sample  (bits_per_sample),
    .data_size        (data_size),
    .duration_seconds (duration_seconds)
  );

  // Passes only when no check failed
  assign header_ok = (error_mask == '0);

endmodule

`default_nettype wire

// File: test/wav_header_checker_test.sv
// Self-checking testbench for the WAV header checker: byte stream stimulus and result scoreboard.
`default_nettype none

module wav_header_checker_test;
  import whc_pkg::*;

  localparam int unsigned TOTAL_BYTES  = 1150;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TAIL_CYCLES  = 40;

  // Header laid out so that byte k of the stream is bits [8k+7:8k]
  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] data_tag;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] byte_rate;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] format;
    logic [31:0] fmt_size;
    logic [31:0] fmt_tag;
    logic [31:0] wave_tag;
    logic [31:0] riff_size;
    logic [31:0] riff_tag;
  } wav_header_t;

  typedef struct packed {
    logic             ok;
    logic [ERR_W-1:0] mask;
    logic [31:0]      rate;
    logic [31:0]      byte_rate;
    logic [15:0]      bits;
    logic [31:0]      data_size;
    logic [31:0]      duration;
  } wav_result_t;

  // Header decoder model plus the queue of results still owed by the block
  class header_scoreboard;
    logic [POS_W-1:0] pos;
    logic [31:0] riff_tag, riff_size, wave_tag, fmt_tag, fmt_size;
    logic [15:0] format, channels, align, bits;
    logic [31:0] rate, byte_rate, data_tag;
    logic [23:0] size_low;
    wav_result_t due_results[$];
    int unsigned failures;
    int unsigned bytes_taken;

    function new();
      pos = '0;
      riff_tag = '0; riff_size = '0; wave_tag = '0; fmt_tag = '0; fmt_size = '0;
      format = '0; channels = '0; align = '0; bits = '0;
      rate = '0; byte_rate = '0; data_tag = '0; size_low = '0;
      failures = 0;
      bytes_taken = 0;
    endfunction

    // One accepted byte; the last header byte queues the decoded result
    function void take_byte(logic [7:0] b, logic s);
      logic [31:0] dsize;
      logic [33:0] size_sum;
      logic [63:0] want_br;
      logic [63:0] want_ba;
      wav_result_t r;
      bytes_taken++;
      if (s) pos = '0;
      if (pos >= POS_END) return;
      if (pos < POS_RIFF_SIZE)        riff_tag  = {b, riff_tag[31:8]};
      else if (pos < POS_WAVE_TAG)    riff_size = {b, riff_size[31:8]};
      else if (pos < POS_FMT_TAG)     wave_tag  = {b, wave_tag[31:8]};
      else if (pos < POS_FMT_SIZE)    fmt_tag   = {b, fmt_tag[31:8]};
      else if (pos < POS_FORMAT)      fmt_size  = {b, fmt_size[31:8]};
      else if (pos < POS_CHANNELS)    format    = {b, format[15:8]};
      else if (pos < POS_RATE)        channels  = {b, channels[15:8]};
      else if (pos < POS_BYTE_RATE)   rate      = {b, rate[31:8]};
      else if (pos < POS_BLOCK_ALIGN) byte_rate = {b, byte_rate[31:8]};
      else if (pos < POS_BITS)        align     = {b, align[15:8]};
      else if (pos < POS_DATA_TAG)    bits      = {b, bits[15:8]};
      else if (pos < POS_DATA_SIZE)   data_tag  = {b, data_tag[31:8]};
      else if (pos < POS_LAST)        size_low  = {b, size_low[23:8]};
      if (pos == POS_LAST) begin
        dsize    = {b, size_low};
        size_sum = RIFF_SIZE_BASE + 34'(fmt_size) + 34'(dsize);
        want_br  = (64'(rate) * 64'(channels) * 64'(bits)) >> 3;
        want_ba  = (64'(channels) * 64'(bits)) >> 3;
        r.mask = '0;
        r.mask[ERR_RIFF]        = riff_tag != TAG_RIFF;
        r.mask[ERR_RIFF_SIZE]   = 34'(riff_size) != size_sum;
        r.mask[ERR_WAVE]        = wave_tag != TAG_WAVE;
        r.mask[ERR_FMT]         = fmt_tag != TAG_FMT;
        r.mask[ERR_FMT_SIZE]    = fmt_size != FMT_SIZE_PCM;
        r.mask[ERR_PCM]         = format != FORMAT_PCM;
        r.mask[ERR_MONO]        = channels != CHANNELS_MONO;
        r.mask[ERR_RATE]        = rate == '0;
        r.mask[ERR_BYTE_RATE]   = 64'(byte_rate) != want_br;
        r.mask[ERR_BLOCK_ALIGN] = 64'(align) != want_ba;
        r.mask[ERR_BITS]        = bits == '0;
        r.mask[ERR_DATA]        = data_tag != TAG_DATA;
        r.mask[ERR_DATA_SIZE]   = dsize == '0;
        r.ok        = r.mask == '0;
        r.rate      = rate;
        r.byte_rate = byte_rate;
        r.bits      = bits;
        r.data_size = dsize;
        r.duration  = (byte_rate != '0) ? dsize / byte_rate : '0;
        due_results.push_back(r);
      end
      pos = pos + 1'b1;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t result %s: expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // One result transfer, checked against the oldest queued result
    function void check_result(wav_result_t got);
      wav_result_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t result with none outstanding: mask %0h", $time, got.mask);
        return;
      end
      want = due_results.pop_front();
      compare_field("header_ok", 32'(want.ok), 32'(got.ok));
      compare_field("error_mask", 32'(want.mask), 32'(got.mask));
      compare_field("sample_rate", want.rate, got.rate);
      compare_field("byte_rate", want.byte_rate, got.byte_rate);
      compare_field("bits_per_sample", 32'(want.bits), 32'(got.bits));
      compare_field("data_size", want.data_size, got.data_size);
      compare_field("duration_seconds", want.duration, got.duration);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        hdr_valid = 1'b0;
  logic        hdr_stall;
  logic [7:0]  data_byte = '0;
  logic        start_req = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        header_ok;
  logic [12:0] error_mask;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] bits_per_sample;
  logic [31:0] data_size;
  logic [31:0] duration_seconds;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          moved;
  wav_result_t seen;
  header_scoreboard sb = new();

  wav_header_checker dut (
    .clk              (clk),
    .rst              (rst),
    .hdr_valid        (hdr_valid),
    .hdr_stall        (hdr_stall),
    .data_byte        (data_byte),
    .start_req        (start_req),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .header_ok        (header_ok),
    .error_mask       (error_mask),
    .sample_rate      (sample_rate),
    .byte_rate        (byte_rate),
    .bits_per_sample  (bits_per_sample),
    .data_size        (data_size),
    .duration_seconds (duration_seconds)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (res_valid === 1'b1 && res_stall === 1'b0) begin
        seen.ok        = header_ok;
        seen.mask      = error_mask;
        seen.rate      = sample_rate;
        seen.byte_rate = byte_rate;
        seen.bits      = bits_per_sample;
        seen.data_size = data_size;
        seen.duration  = duration_seconds;
        sb.check_result(seen);
        moved = 1'b1;
      end
      if (hdr_valid && hdr_stall === 1'b0) begin
        sb.take_byte(data_byte, start_req);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("wav_header_checker: mismatch");
        $finish;
      end
    end
  end

  // Idle schedule over the whole run, by transfers accepted so far
  function automatic void set_idle_phase();
    if (sb.bytes_taken < TOTAL_BYTES / 3) begin
      tx_idle_pct = 21;
      rx_idle_pct = 88;
    end else if (sb.bytes_taken < 2 * TOTAL_BYTES / 3) begin
      tx_idle_pct = 88;
      rx_idle_pct = 21;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic s);
    set_idle_phase();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      hdr_valid <= 1'b0;
      @(posedge clk);
    end
    hdr_valid <= 1'b1;
    data_byte <= b;
    start_req <= s;
    @(posedge clk);
    while (hdr_stall !== 1'b0) @(posedge clk);
  endtask

  // First nbytes of a header; start flag only on byte 0
  task automatic send_header(input wav_header_t h, input int unsigned nbytes,
                             input logic first_start);
    logic [351:0] raw;
    raw = h;
    for (int unsigned k = 0; k < nbytes; k++)
      send_byte(raw[8*k +: 8], first_start && k == 0);
  endtask

  // Bytes after a complete header, which the block drops
  task automatic send_trailer(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  function automatic wav_header_t make_header(logic [31:0] rate, logic [15:0] bits,
                                              logic [31:0] dsize);
    wav_header_t h;
    h.riff_tag  = TAG_RIFF;
    h.riff_size = 32'(RIFF_SIZE_BASE) + FMT_SIZE_PCM + dsize;
    h.wave_tag  = TAG_WAVE;
    h.fmt_tag   = TAG_FMT;
    h.fmt_size  = FMT_SIZE_PCM;
    h.format    = FORMAT_PCM;
    h.channels  = CHANNELS_MONO;
    h.rate      = rate;
    h.byte_rate = 32'((64'(rate) * 64'(bits)) >> 3);
    h.align     = bits >> 3;
    h.bits      = bits;
    h.data_tag  = TAG_DATA;
    h.data_size = dsize;
    return h;
  endfunction

  function automatic wav_header_t random_header();
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] dsize;
    case ($urandom_range(0, 4))
      0:       rate = 32'd8000;
      1:       rate = 32'd22050;
      2:       rate = 32'd44100;
      3:       rate = 32'd48000;
      default: rate = $urandom_range(1, 192000);
    endcase
    if ($urandom_range(0, 9) == 0) rate = $urandom;
    case ($urandom_range(0, 4))
      0:       bits = 16'd8;
      1:       bits = 16'd16;
      2:       bits = 16'd24;
      3:       bits = 16'd32;
      default: bits = 16'($urandom_range(1, 65535));
    endcase
    dsize = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1 << 20);
    return make_header(rate, bits, dsize);
  endfunction

  // Change the field that the given check looks at, usually so that the check fails
  function automatic wav_header_t corrupt(wav_header_t h, int unsigned check);
    logic [31:0] flip;
    flip = 32'd1 << $urandom_range(0, 31);
    case (check)
      ERR_RIFF:        h.riff_tag  ^= flip;
      ERR_RIFF_SIZE:   h.riff_size ^= flip;
      ERR_WAVE:        h.wave_tag  ^= flip;
      ERR_FMT:         h.fmt_tag   ^= flip;
      ERR_FMT_SIZE:    h.fmt_size  ^= flip;
      ERR_PCM:         h.format    = 16'($urandom);
      ERR_MONO:        h.channels  = 16'($urandom_range(0, 8));
      ERR_RATE:        h.rate      = '0;
      ERR_BYTE_RATE:   h.byte_rate ^= flip;
      ERR_BLOCK_ALIGN: h.align     ^= flip[15:0] | 16'd1;
      ERR_BITS:        h.bits      = '0;
      ERR_DATA:        h.data_tag  ^= flip;
      ERR_DATA_SIZE:   h.data_size = '0;
      default:         h.riff_tag  = $urandom;
    endcase
    return h;
  endfunction

  initial begin
    wav_header_t h;
    int unsigned pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: first header relies on the reset position, no start flag
    send_header(make_header(32'd8000, 16'd8, 32'd1000), 44, 1'b0);
    send_header(make_header(32'd44100, 16'd16, 32'd176400), 44, 1'b1);
    send_trailer(3);
    send_header('0, 44, 1'b1);
    send_header('1, 44, 1'b1);
    // zero byte rate: duration forced to zero
    h = make_header(32'd48000, 16'd16, 32'd96000);
    h.byte_rate = '0;
    send_header(h, 44, 1'b1);
    // restart part way through, then a size that overflows the riff size
    send_header(make_header(32'd22050, 16'd8, 32'd5), 20, 1'b1);
    send_header(make_header(32'd1, 16'd8, 32'hFFFF_FFFF), 44, 1'b1);
    // zero byte inside a tag
    h = make_header(32'd16000, 16'd16, 32'd640);
    h.data_tag[31:24] = 8'h00;
    send_header(h, 44, 1'b1);
    for (int unsigned c = 0; c < ERR_W; c++)
      send_header(corrupt(random_header(), c), 44, 1'b1);

    // Random: headers with up to two fields corrupted, some cut short, some noise
    while (sb.bytes_taken < TOTAL_BYTES) begin
      h = random_header();
      repeat ($urandom_range(0, 2)) h = corrupt(h, $urandom_range(0, ERR_W - 1));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_header(h, 44, 1'b1);
        send_trailer($urandom_range(0, 3));
      end else if (pick < 85) begin
        send_header(h, $urandom_range(1, 43), 1'b1);
      end else begin
        repeat ($urandom_range(1, 50)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end
    hdr_valid <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // Drain outstanding results, then let the block settle
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("wav_header_checker: match");
    end else begin
      $display("wav_header_checker: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
